// ----- src/tfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and widths for the triangle placement block
// fixed field widths and the entry and sideband structs passed between units
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int SIDE_W = 31;          // side length width
	localparam int SQ_W   = 2 * SIDE_W;  // square of a side
	localparam int NUM_W  = SQ_W + 1;    // sum of two squares
	localparam int DEN_W  = SIDE_W + 1;  // twice the base
	localparam int X_W    = SIDE_W + 1;  // signed x coordinate

	// classified item handed from front to back
	typedef struct packed {
		logic              err;
		logic [SIDE_W-1:0] a;
		logic [SQ_W-1:0]   a2;
		logic [SQ_W-1:0]   b2;
		logic [SQ_W-1:0]   c2;
	} fent_t;

	// sideband carried through the divider
	typedef struct packed {
		logic              err;
		logic [SIDE_W-1:0] a;
		logic [SQ_W-1:0]   c2;
	} dside_t;

	// sideband carried through the square root
	typedef struct packed {
		logic                err;
		logic [SIDE_W-1:0]   a;
		logic signed [X_W-1:0] x;
	} sside_t;

endpackage

// ----- src/triangle_from_three_sides.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_from_three_sides: law of cosines triangle placement
// places a triangle from three side lengths, or flags a bad triple
// ----------------------------------------------------------------------------
// Sides a, b, c are unsigned fixed point; results share their format. A
// triple with a >= b+c or a <= |b-c| comes back with status 1 and zero
// coordinates. Otherwise the second vertex is (a,0) and the third is
// x = (a^2+c^2-b^2)/(2a) truncated toward zero, y = floor(sqrt(c^2-x^2)).
// One triangle is taken every cycle and one result beat leaves per cycle
// while no stall holds them. The path runs through two front stages, the
// queue, one sum stage, the 32-stage divider (an entry stage, then one
// quotient bit per stage), two stages for x squared and the radicand, and
// the 32-stage root. A stall on the output freezes the back pipeline; the
// queue (QUEUE_DEPTH beats) then fills before the input stalls.
// ----------------------------------------------------------------------------
module triangle_from_three_sides import tfs_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SIDE_W-1:0]        side_a,
	input  logic [SIDE_W-1:0]        side_b,
	input  logic [SIDE_W-1:0]        side_c,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     status,
	output logic [SIDE_W-1:0]        second_x,
	output logic signed [X_W-1:0]    third_x,
	output logic [SIDE_W-1:0]        third_y
);

	// front to queue
	logic   push, q_full, q_nonempty, pop;
	fent_t  push_data, head;

	// back pipeline advance: hold everything while the output beat waits
	logic en;

	// sum stage
	logic             v_s1;
	logic [NUM_W-1:0] sum_s1;
	logic [SQ_W-1:0]  b2_s1;
	dside_t           side_s1;

	// divider out
	logic              d_vld, d_neg;
	logic [SIDE_W-1:0] d_quo;
	dside_t            d_side;

	// x squared stage
	logic            v_s2;
	logic [SQ_W-1:0] xsq_s2;
	logic [SQ_W-1:0] c2_s2;
	sside_t          side_s2;

	// radicand stage
	logic            v_s3;
	logic [SQ_W-1:0] rad_s3;
	sside_t          side_s3;

	// root out
	logic              r_vld;
	logic [SIDE_W-1:0] r_root;
	sside_t            r_side;

	assign en  = !(r_vld && out_stall);
	assign pop = q_nonempty && en;

	tfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.side_a    (side_a),
		.side_b    (side_b),
		.side_c    (side_c),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	tfs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.nonempty  (q_nonempty),
		.head      (head)
	);

	// a^2 + c^2 ahead of the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1      <= NUM_W'(head.a2) + NUM_W'(head.c2);
			b2_s1       <= head.b2;
			side_s1.err <= head.err;
			side_s1.a   <= head.a;
			side_s1.c2  <= head.c2;
		end
	end

	tfs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s1),
		.sum      (sum_s1),
		.b2       (b2_s1),
		.in_side  (side_s1),
		.out_vld  (d_vld),
		.out_neg  (d_neg),
		.out_quo  (d_quo),
		.out_side (d_side)
	);

	// signed x and its square; |x| < c for a good triangle, so no saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= d_vld;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s2      <= SQ_W'(d_quo) * SQ_W'(d_quo);
			c2_s2       <= d_side.c2;
			side_s2.err <= d_side.err;
			side_s2.a   <= d_side.a;
			side_s2.x   <= d_neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo});
			// radicand clamped at zero
			rad_s3      <= (c2_s2 > xsq_s2) ? (c2_s2 - xsq_s2) : '0;
			side_s3     <= side_s2;
		end
	end

	tfs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.rad      (rad_s3),
		.in_side  (side_s3),
		.out_vld  (r_vld),
		.out_root (r_root),
		.out_side (r_side)
	);

	// last root stage is the output register; bad triples read as zero
	assign out_valid = r_vld;
	assign status    = r_side.err;
	assign second_x  = r_side.err ? '0 : r_side.a;
	assign third_x   = r_side.err ? '0 : r_side.x;
	assign third_y   = r_side.err ? '0 : r_root;

endmodule

// ----- src/tfs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_front: input stage
// takes side beats, checks the triangle inequality and forms the squares
// ----------------------------------------------------------------------------
module tfs_front import tfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SIDE_W-1:0] side_a,
	input  logic [SIDE_W-1:0] side_b,
	input  logic [SIDE_W-1:0] side_c,
	input  logic              q_full,
	output logic              push,
	output fent_t             push_data
);

	logic              v_s1, v_s2;
	logic [SIDE_W-1:0] a_s1, b_s1, c_s1;
	fent_t             ent_s2;
	logic              fen;
	logic [SIDE_W:0]   bc_sum;
	logic [SIDE_W-1:0] bc_diff;
	logic              err;

	assign fen      = !(v_s2 && q_full);
	assign in_stall = !fen;
	assign push     = v_s2 && !q_full;
	assign push_data = ent_s2;

	assign bc_sum  = {1'b0, b_s1} + {1'b0, c_s1};
	assign bc_diff = (b_s1 >= c_s1) ? (b_s1 - c_s1) : (c_s1 - b_s1);
	assign err     = ({1'b0, a_s1} >= bc_sum) || (a_s1 <= bc_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fen) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			a_s1 <= side_a;
			b_s1 <= side_b;
			c_s1 <= side_c;
			ent_s2.err <= err;
			ent_s2.a   <= a_s1;
			ent_s2.a2  <= SQ_W'(a_s1) * SQ_W'(a_s1);
			ent_s2.b2  <= SQ_W'(b_s1) * SQ_W'(b_s1);
			ent_s2.c2  <= SQ_W'(c_s1) * SQ_W'(c_s1);
		end
	end

endmodule

// ----- src/tfs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_queue: decoupling queue
// short fifo of classified items between the front and the back
// ----------------------------------------------------------------------------
module tfs_queue import tfs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  fent_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output fent_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fent_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/tfs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_div: pipelined divider
// signed numerator over twice the base, one quotient bit per stage
// ----------------------------------------------------------------------------
module tfs_div import tfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  sum,
	input  logic [SQ_W-1:0]   b2,
	input  dside_t            in_side,
	output logic              out_vld,
	output logic              out_neg,
	output logic [SIDE_W-1:0] out_quo,
	output dside_t            out_side
);

	logic              vld_q  [SIDE_W+1];
	logic              neg_q  [SIDE_W+1];
	logic [NUM_W-1:0]  rem_q  [SIDE_W+1];
	logic [DEN_W-1:0]  den_q  [SIDE_W+1];
	logic [SIDE_W-1:0] quo_q  [SIDE_W+1];
	dside_t            side_q [SIDE_W+1];
	logic              neg;

	assign neg = (sum < NUM_W'(b2));

	// entry stage: magnitude and sign of the numerator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0]  <= neg;
			rem_q[0]  <= neg ? (NUM_W'(b2) - sum) : (sum - NUM_W'(b2));
			den_q[0]  <= {in_side.a, 1'b0};
			quo_q[0]  <= '0;
			side_q[0] <= in_side;
		end
	end

	for (genvar k = 0; k < SIDE_W; k++) begin : g_st
		localparam int B = SIDE_W - 1 - k;
		logic [NUM_W:0] dsh;
		logic [NUM_W:0] trial;

		assign dsh   = (NUM_W + 1)'(den_q[k]) << B;
		assign trial = {1'b0, rem_q[k]} - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[k+1]  <= neg_q[k];
				den_q[k+1]  <= den_q[k];
				side_q[k+1] <= side_q[k];
				rem_q[k+1]  <= trial[NUM_W] ? rem_q[k] : trial[NUM_W-1:0];
				// bit B is still clear here, so or-ing in the new bit sets it
				quo_q[k+1]  <= quo_q[k] | ({{(SIDE_W-1){1'b0}}, ~trial[NUM_W]} << B);
			end
		end
	end

	assign out_vld  = vld_q[SIDE_W];
	assign out_neg  = neg_q[SIDE_W];
	assign out_quo  = quo_q[SIDE_W];
	assign out_side = side_q[SIDE_W];

endmodule

// ----- src/tfs_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_sqrt: pipelined floor square root
// digit by digit, one root bit per stage
// ----------------------------------------------------------------------------
module tfs_sqrt import tfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SQ_W-1:0]   rad,
	input  sside_t            in_side,
	output logic              out_vld,
	output logic [SIDE_W-1:0] out_root,
	output sside_t            out_side
);

	logic              vld_q  [SIDE_W+1];
	logic [SQ_W-1:0]   rem_q  [SIDE_W+1];
	logic [SIDE_W-1:0] root_q [SIDE_W+1];
	sside_t            side_q [SIDE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= rad;
			root_q[0] <= '0;
			side_q[0] <= in_side;
		end
	end

	for (genvar k = 0; k < SIDE_W; k++) begin : g_st
		localparam int B = SIDE_W - 1 - k;
		logic [SQ_W+1:0] t;
		logic [SQ_W+1:0] trial;

		// (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
		assign t     = ((SQ_W + 2)'(root_q[k]) << (B + 1)) + ((SQ_W + 2)'(1) << (2 * B));
		assign trial = {2'b00, rem_q[k]} - t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k+1] <= side_q[k];
				rem_q[k+1]  <= trial[SQ_W+1] ? rem_q[k] : trial[SQ_W-1:0];
				// bit B is still clear here, so or-ing in the new bit sets it
				root_q[k+1] <= root_q[k] | ({{(SIDE_W-1){1'b0}}, ~trial[SQ_W+1]} << B);
			end
		end
	end

	assign out_vld  = vld_q[SIDE_W];
	assign out_root = root_q[SIDE_W];
	assign out_side = side_q[SIDE_W];

endmodule
